/* hdl/regularized_forward_substitution_defines.svh */
// Assertion macros shared by the regularized forward substitution RTL.
`ifndef REGULARIZED_FORWARD_SUBSTITUTION_DEFINES_SVH
`define REGULARIZED_FORWARD_SUBSTITUTION_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define RFS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define RFS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/rfs_pkg.sv */
// Package with types, constants and saturation helper for the forward substitution block.
`default_nettype none
package rfs_pkg;

   localparam int DATA_W        = 32;
   localparam int FRAC_W        = 16;
   localparam int ORDER_W       = 7;
   localparam int ROW_OUT_W     = 6;
   localparam int CSR_IDX_W     = 2;
   localparam int MAX_ORDER_DEF = 64;

   localparam logic signed [DATA_W-1:0] SAT_POS = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_NEG = 32'sh8000_0001;
   localparam logic signed [64:0] SAT_POS_W = 65'sd2147483647;
   localparam logic signed [64:0] SAT_NEG_W = -65'sd2147483647;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LAMBDA = 2'd0,
      CSR_ORDER  = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_ACC,
      ST_DEN,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Clamp a wide signed value to the symmetric Q16.16 range.
   function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [64:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_POS_W) begin
         r = SAT_POS;
      end else if (v < SAT_NEG_W) begin
         r = SAT_NEG;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/rfs_chan_if.sv */
// Handshake channel interfaces: element input, solution output and register writes.
`default_nettype none
interface rfs_req_if;
   import rfs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     first_of_system;
   logic signed [DATA_W-1:0] elem_re;
   logic signed [DATA_W-1:0] elem_im;
   logic signed [DATA_W-1:0] rhs_re;
   logic signed [DATA_W-1:0] rhs_im;
   modport source (output valid, first_of_system, elem_re, elem_im, rhs_re, rhs_im,
                   input ready);
   modport sink (input valid, first_of_system, elem_re, elem_im, rhs_re, rhs_im,
                 output ready);
endinterface

interface rfs_rsp_if;
   import rfs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sol_re;
   logic signed [DATA_W-1:0] sol_im;
   logic [ROW_OUT_W-1:0]     row_index;
   logic                     last;
   logic                     div_by_zero;
   modport source (output valid, sol_re, sol_im, row_index, last, div_by_zero,
                   input ready);
   modport sink (input valid, sol_re, sol_im, row_index, last, div_by_zero,
                 output ready);
endinterface

interface rfs_csr_if;
   import rfs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/rfs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rfs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* hdl/rfs_div.sv */
// Bit-serial restoring divider: saturated Q16.16 quotient of (num * 2^16) / den.
`default_nettype none
module rfs_div import rfs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [63:0]       num,
   input  logic [63:0]              den,
   output div_stat_type             stat,
   output logic signed [DATA_W-1:0] quo
);
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [63:0]       rem_ff, rem_in;
   logic [31:0]       low_ff, low_in;
   logic [31:0]       q_ff, q_in;
   logic [63:0]       den_ff, den_in;
   logic              neg_ff, neg_in;
   logic              ovf_ff, ovf_in;
   logic [63:0]       mag;
   logic [63:0]       r2;
   logic [DATA_W-1:0] mag_q;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      mag     = num[63] ? 64'(-num) : 64'(num);
      r2      = {rem_ff[62:0], low_ff[31]};
      if (start) begin
         // The quotient fits in 32 bits only when mag / 2^16 is below den.
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         rem_in  = {16'd0, mag[63:16]};
         low_in  = {mag[15:0], 16'd0};
         q_in    = '0;
         den_in  = den;
         neg_in  = num[63];
         ovf_in  = {16'd0, mag[63:16]} >= den;
      end else if (busy_ff) begin
         if (r2 >= den_ff) begin
            rem_in = r2 - den_ff;
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = r2;
            q_in   = {q_ff[30:0], 1'b0};
         end
         low_in = {low_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
   end

   assign mag_q     = (ovf_ff || q_ff[31]) ? SAT_POS : q_ff;
   assign quo       = neg_ff ? DATA_W'(-mag_q) : mag_q;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
endmodule
`default_nettype wire

/* hdl/regularized_forward_substitution.sv */
// Top level: regularized complex lower-triangular forward substitution in Q16.16.
//
//   Channel    Direction   Carries
//   req_chan   in          one lower-triangle element with its row's right-hand side
//   rsp_chan   out         one solved unknown, its row index and flags
//   csr_chan   in          register writes: lambda (index 0), system order (index 1)
//
// An element below the diagonal passes capture, saturation, the shared complex
// multiplier and the accumulate. A diagonal element ends instead in the denominator step
// and the two bit-serial dividers that produce 32 quotient bits one bit per cycle.
// Reset is synchronous and active high; it resets the control state and the configuration
// registers, while the solution memory holds nothing valid until rows are solved.
// A solved word waits in the output register while the next element is accepted;
// only a second diagonal finding that register still full stalls the block.
`include "regularized_forward_substitution_defines.svh"
`default_nettype none
module regularized_forward_substitution import rfs_pkg::*; #(
   parameter int MAX_ORDER = MAX_ORDER_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rfs_req_if.sink   req_chan,
   rfs_rsp_if.source rsp_chan,
   rfs_csr_if.sink   csr_chan
);
   localparam int ROW_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int CNT_W = $clog2(MAX_ORDER + 1);
   localparam int ORD_W = (CNT_W > ORDER_W) ? CNT_W : ORDER_W;

   // Configuration registers.
   logic signed [DATA_W-1:0] lambda_ff, lambda_in;
   logic [ORDER_W-1:0]       order_ff, order_in;

   state_type state_ff, state_in;

   // Captured element word.
   logic signed [DATA_W-1:0] elem_re_ff, elem_re_in, elem_im_ff, elem_im_in;
   logic signed [DATA_W-1:0] rhs_re_ff, rhs_re_in, rhs_im_ff, rhs_im_in;

   // Saturated operands and multiplier outputs.
   logic signed [DATA_W-1:0] er_ff, er_in, ei_ff, ei_in, nr_ff, nr_in, ni_ff, ni_in;
   logic                     mac_ff, mac_in;
   logic signed [63:0]       p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in;
   logic signed [63:0]       num_re_ff, num_re_in, num_im_ff, num_im_in;
   logic                     dz_ff, dz_in;

   // Row state.
   logic signed [63:0] sum_re_ff, sum_re_in, sum_im_ff, sum_im_in;
   logic [ROW_W-1:0]   row_ff, row_in, col_ff, col_in;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] sol_re_ff, sol_re_in, sol_im_ff, sol_im_in;
   logic [ROW_OUT_W-1:0]     row_idx_ff, row_idx_in;
   logic                     last_ff, last_in, dzo_ff, dzo_in;

   logic                     req_take;
   logic                     out_load;
   logic signed [DATA_W-1:0] a0, b0, a1, b1, a2, b2, a3, b3;
   logic signed [63:0]       m0, m1, m2, m3;
   logic [63:0]              den_w;
   logic                     div_start;
   div_stat_type             stat_re, stat_im;
   logic signed [DATA_W-1:0] quo_re, quo_im;
   logic [ORD_W-1:0]         sys_ord, ord;
   logic                     is_last;
   logic [31:0]              row_ext;
   logic                     mem_we;
   logic [ROW_W-1:0]         mem_raddr;
   logic [2*DATA_W-1:0]      mem_wdata, mem_rdata;
   logic signed [DATA_W-1:0] xr, xi;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Effective order: zero acts as one, anything above the memory depth as the depth.
   assign sys_ord = ORD_W'(order_ff);
   assign ord     = (sys_ord == '0) ? ORD_W'(1) :
                    (sys_ord > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : sys_ord;
   assign is_last = (ORD_W'(row_ff) + ORD_W'(1)) >= ord;
   assign row_ext = 32'(row_ff);

   // The read address holds still from acceptance until the multiply uses the data.
   assign mem_raddr = (req_take && req_chan.first_of_system) ? '0 : col_ff;
   assign xr        = mem_rdata[DATA_W-1:0];
   assign xi        = mem_rdata[2*DATA_W-1:DATA_W];

   rfs_ram #(
      .WIDTH (2 * DATA_W),
      .DEPTH (MAX_ORDER)
   ) u_sol_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (row_ff),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Shared complex multiplier: product terms for the accumulate, the numerator
   // of the division, or the squared magnitude of the diagonal.
   always_comb begin
      if (state_ff == ST_DEN) begin
         a0 = er_ff; b0 = er_ff;
         a1 = ei_ff; b1 = ei_ff;
         a2 = ni_ff; b2 = er_ff;
         a3 = nr_ff; b3 = ei_ff;
      end else if (mac_ff) begin
         a0 = er_ff; b0 = xr;
         a1 = ei_ff; b1 = xi;
         a2 = er_ff; b2 = xi;
         a3 = ei_ff; b3 = xr;
      end else begin
         a0 = nr_ff; b0 = er_ff;
         a1 = ni_ff; b1 = ei_ff;
         a2 = ni_ff; b2 = er_ff;
         a3 = nr_ff; b3 = ei_ff;
      end
   end

   assign m0    = a0 * b0;
   assign m1    = a1 * b1;
   assign m2    = a2 * b2;
   assign m3    = a3 * b3;
   assign den_w = 64'(p0_ff + p1_ff);

   rfs_div u_div_re (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_re_ff),
      .den   (den_w),
      .stat  (stat_re),
      .quo   (quo_re)
   );

   rfs_div u_div_im (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_im_ff),
      .den   (den_w),
      .stat  (stat_im),
      .quo   (quo_im)
   );

   // Configuration writes must arrive only while the block is idle; the block does not enforce it.
   always_comb begin
      lambda_in = lambda_ff;
      order_in  = order_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_LAMBDA: lambda_in = csr_chan.data;
            CSR_ORDER:  order_in  = csr_chan.data[ORDER_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      elem_re_in   = elem_re_ff;
      elem_im_in   = elem_im_ff;
      rhs_re_in    = rhs_re_ff;
      rhs_im_in    = rhs_im_ff;
      er_in        = er_ff;
      ei_in        = ei_ff;
      nr_in        = nr_ff;
      ni_in        = ni_ff;
      mac_in       = mac_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      p3_in        = p3_ff;
      num_re_in    = num_re_ff;
      num_im_in    = num_im_ff;
      dz_in        = dz_ff;
      sum_re_in    = sum_re_ff;
      sum_im_in    = sum_im_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      sol_re_in    = sol_re_ff;
      sol_im_in    = sol_im_ff;
      row_idx_in   = row_idx_ff;
      last_in      = last_ff;
      dzo_in       = dzo_ff;
      div_start    = 1'b0;
      out_load     = 1'b0;
      mem_we       = 1'b0;
      mem_wdata    = {quo_im, quo_re};
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               elem_re_in = req_chan.elem_re;
               elem_im_in = req_chan.elem_im;
               rhs_re_in  = req_chan.rhs_re;
               rhs_im_in  = req_chan.rhs_im;
               if (req_chan.first_of_system) begin
                  row_in    = '0;
                  col_in    = '0;
                  sum_re_in = '0;
                  sum_im_in = '0;
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            er_in  = sat_wide({{33{elem_re_ff[DATA_W-1]}}, elem_re_ff}
                              + {{33{lambda_ff[DATA_W-1]}}, lambda_ff});
            ei_in  = sat_wide({{33{elem_im_ff[DATA_W-1]}}, elem_im_ff});
            nr_in  = sat_wide({{33{rhs_re_ff[DATA_W-1]}}, rhs_re_ff}
                              - {sum_re_ff[63], sum_re_ff});
            ni_in  = sat_wide({{33{rhs_im_ff[DATA_W-1]}}, rhs_im_ff}
                              - {sum_im_ff[63], sum_im_ff});
            mac_in = col_ff < row_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            p0_in    = m0;
            p1_in    = m1;
            p2_in    = m2;
            p3_in    = m3;
            state_in = mac_ff ? ST_ACC : ST_DEN;
         end
         ST_ACC: begin
            // Each term is floored to Q16.16 before it joins the running sum.
            sum_re_in = sum_re_ff + ((p0_ff - p1_ff) >>> FRAC_W);
            sum_im_in = sum_im_ff + ((p2_ff + p3_ff) >>> FRAC_W);
            col_in    = col_ff + ROW_W'(1);
            state_in  = ST_IDLE;
         end
         ST_DEN: begin
            num_re_in = p0_ff + p1_ff;
            num_im_in = p2_ff - p3_ff;
            p0_in     = m0;
            p1_in     = m1;
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            dz_in     = (den_w == '0);
            div_start = (den_w != '0);
            state_in  = (den_w == '0) ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            if (stat_re.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            out_load = !rsp_valid_ff || rsp_chan.ready;
            if (out_load) begin
               rsp_valid_in = 1'b1;
               sol_re_in    = dz_ff ? '0 : quo_re;
               sol_im_in    = dz_ff ? '0 : quo_im;
               row_idx_in   = row_ext[ROW_OUT_W-1:0];
               last_in      = is_last;
               dzo_in       = dz_ff;
               mem_we       = 1'b1;
               mem_wdata    = dz_ff ? '0 : {quo_im, quo_re};
               sum_re_in    = '0;
               sum_im_in    = '0;
               col_in       = '0;
               row_in       = is_last ? '0 : row_ff + ROW_W'(1);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lambda_ff    <= '0;
         order_ff     <= ORDER_W'(MAX_ORDER_DEF);
         sum_re_ff    <= '0;
         sum_im_ff    <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         mac_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lambda_ff    <= lambda_in;
         order_ff     <= order_in;
         sum_re_ff    <= sum_re_in;
         sum_im_ff    <= sum_im_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         mac_ff       <= mac_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      elem_re_ff <= elem_re_in;
      elem_im_ff <= elem_im_in;
      rhs_re_ff  <= rhs_re_in;
      rhs_im_ff  <= rhs_im_in;
      er_ff      <= er_in;
      ei_ff      <= ei_in;
      nr_ff      <= nr_in;
      ni_ff      <= ni_in;
      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      p3_ff      <= p3_in;
      num_re_ff  <= num_re_in;
      num_im_ff  <= num_im_in;
      dz_ff      <= dz_in;
      sol_re_ff  <= sol_re_in;
      sol_im_ff  <= sol_im_in;
      row_idx_ff <= row_idx_in;
      last_ff    <= last_in;
      dzo_ff     <= dzo_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.sol_re      = sol_re_ff;
   assign rsp_chan.sol_im      = sol_im_ff;
   assign rsp_chan.row_index   = row_idx_ff;
   assign rsp_chan.last        = last_ff;
   assign rsp_chan.div_by_zero = dzo_ff;

   // The column being accumulated never passes the row being solved.
   `RFS_ASSERT_SAME(a_col_le_row, 1'b1, col_ff <= row_ff, "column ran past the row")
   // Both dividers run in lockstep and finish together.
   `RFS_ASSERT_SAME(a_div_lockstep, 1'b1, stat_re.done == stat_im.done, "dividers out of step")
   // While waiting on the division, a divider is running or has just finished.
   `RFS_ASSERT_SAME(a_div_live, state_ff == ST_DIV, stat_re.busy || stat_re.done,
      "waiting on an idle divider")
   // A zero diagonal gives a zero solution word.
   `RFS_ASSERT_SAME(a_dz_zero, rsp_valid_ff && dzo_ff, sol_re_ff == '0 && sol_im_ff == '0,
      "zero divisor with nonzero solution")
   // A loaded solution word is offered on the next cycle.
   `RFS_ASSERT_NEXT(a_out_load, out_load, rsp_valid_ff, "loaded solution not offered")
endmodule
`default_nettype wire

/* test/rfs_checker.sv */
// Checker for the forward substitution block: predicts each solved word and compares it.
`default_nettype none
module rfs_checker import rfs_pkg::*; (
   input  logic clock,
   input  logic reset,
   rfs_req_if   req,
   rfs_rsp_if   rsp,
   rfs_csr_if   csr,
   output int   err_count,
   output int   pending
);

   localparam int STORE_DEPTH = 64;
   localparam logic signed [127:0] Q_MAX = 128'sd2147483647;

   typedef struct packed {
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
      logic [ROW_OUT_W-1:0]     row;
      logic                     last;
      logic                     dz;
   } solution_type;

   logic signed [63:0] lambda_q;
   int unsigned        order_cfg;
   logic signed [63:0] known_re [STORE_DEPTH];
   logic signed [63:0] known_im [STORE_DEPTH];
   logic signed [63:0] acc_re;
   logic signed [63:0] acc_im;
   int unsigned        row_ptr;
   int unsigned        col_ptr;
   solution_type       solutions_due[$];

   function automatic logic signed [127:0] clamp_q(input logic signed [127:0] v);
      if (v > Q_MAX) return Q_MAX;
      if (v < -Q_MAX) return -Q_MAX;
      return v;
   endfunction

   // Quotient n * 2^16 / d truncated toward zero, then clamped; d is positive.
   function automatic logic signed [127:0] quotient_q(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
      logic signed [127:0] mag;
      logic signed [127:0] q;
      mag = (n < 0) ? -n : n;
      q = (mag <<< FRAC_W) / d;
      if (q > Q_MAX) q = Q_MAX;
      return (n < 0) ? -q : q;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $time);
      err_count++;
   endtask

   // Substitution step for one accepted element word.
   task automatic solve_element();
      int unsigned         ord;
      logic signed [127:0] er, ei, xr, xi, nr, ni, den, t;
      solution_type        s;
      ord = (order_cfg == 0) ? 1 : ((order_cfg > STORE_DEPTH) ? STORE_DEPTH : order_cfg);
      if (req.first_of_system) begin
         row_ptr = 0;
         col_ptr = 0;
         acc_re = 0;
         acc_im = 0;
      end
      er = req.elem_re;
      er = clamp_q(er + lambda_q);
      ei = req.elem_im;
      ei = clamp_q(ei);
      if (col_ptr < row_ptr && col_ptr < STORE_DEPTH) begin
         xr = known_re[col_ptr];
         xi = known_im[col_ptr];
         t = (er * xr - ei * xi) >>> FRAC_W;
         acc_re = acc_re + t[63:0];
         t = (er * xi + ei * xr) >>> FRAC_W;
         acc_im = acc_im + t[63:0];
         col_ptr++;
         return;
      end
      nr = req.rhs_re;
      nr = clamp_q(nr - acc_re);
      ni = req.rhs_im;
      ni = clamp_q(ni - acc_im);
      den = er * er + ei * ei;
      xr = 0;
      xi = 0;
      if (den != 0) begin
         xr = quotient_q(nr * er + ni * ei, den);
         xi = quotient_q(ni * er - nr * ei, den);
      end
      known_re[row_ptr] = xr[63:0];
      known_im[row_ptr] = xi[63:0];
      s.re = xr[DATA_W-1:0];
      s.im = xi[DATA_W-1:0];
      s.row = row_ptr[ROW_OUT_W-1:0];
      s.last = (row_ptr + 1 >= ord);
      s.dz = (den == 0);
      solutions_due.push_back(s);
      acc_re = 0;
      acc_im = 0;
      col_ptr = 0;
      row_ptr = s.last ? 0 : row_ptr + 1;
   endtask

   initial begin
      err_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      solution_type w;
      if (reset) begin
         lambda_q = 0;
         order_cfg = STORE_DEPTH;
         acc_re = 0;
         acc_im = 0;
         row_ptr = 0;
         col_ptr = 0;
         solutions_due.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_LAMBDA) lambda_q = $signed(csr.data);
            else if (csr.index == CSR_ORDER) order_cfg = csr.data[ORDER_W-1:0];
         end
         if (req.valid && req.ready) solve_element();
         if (rsp.valid && rsp.ready) begin
            if (solutions_due.size() == 0) begin
               report("unexpected word", {rsp.sol_re, rsp.sol_im}, 64'd0);
            end else begin
               w = solutions_due.pop_front();
               if (rsp.sol_re !== w.re) report("sol_re", rsp.sol_re, w.re);
               if (rsp.sol_im !== w.im) report("sol_im", rsp.sol_im, w.im);
               if (rsp.row_index !== w.row) report("row_index", rsp.row_index, w.row);
               if (rsp.last !== w.last) report("last", rsp.last, w.last);
               if (rsp.div_by_zero !== w.dz) report("div_by_zero", rsp.div_by_zero, w.dz);
            end
         end
      end
      pending = solutions_due.size();
   end

endmodule
`default_nettype wire

/* test/tb.sv */
// Testbench top: stimulus, register writes and the verdict for the forward substitution block.
`default_nettype none
module tb;
   import rfs_pkg::*;

   // The run is stopped hard if it ever gets this far.
   localparam int CYCLE_LIMIT = 1000000;
   // Cycles to let pass after the last expected word, covering a full diagonal.
   localparam int SETTLE = 80;
   localparam int Q_ONE = 65536;

   logic clock;
   logic reset;
   int   err_count;
   int   pending;
   int   cycles;
   int   tx_pct;
   int   rx_pct;
   int   words_sent;
   int   lambda_now;
   int   order_now;

   rfs_req_if req_chan ();
   rfs_rsp_if rsp_chan ();
   rfs_csr_if csr_chan ();

   regularized_forward_substitution i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   rfs_checker i_checker (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr       (csr_chan),
      .err_count (err_count),
      .pending   (pending)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // The receiver stalls at random; rx_pct is its stall rate in percent.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rx_pct);
   end

   // Watchdog: a hung block or a lost word ends the run here.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // A Q16.16 value: mostly small, sometimes full range, sometimes an extreme.
   function automatic int rand_q();
      case ($urandom_range(9))
         0: return int'($urandom);
         1: begin
            case ($urandom_range(4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 0;
               3: return 1;
               default: return -1;
            endcase
         end
         default: return int'($urandom_range(0, 524288)) - 262144;
      endcase
   endfunction

   // A diagonal that is normally well away from zero after lambda is added.
   // Now and then it cancels lambda exactly, which zeroes the real part of the diagonal.
   function automatic int rand_diag_re();
      int v;
      if ($urandom_range(29) == 0) return -lambda_now;
      v = int'($urandom_range(Q_ONE / 2, 4 * Q_ONE));
      return ($urandom_range(1) == 1) ? v - lambda_now : -v - lambda_now;
   endfunction

   // One element word. The sender's idle gap is drawn after acceptance, so with no gap valid stays
   // high between back-to-back words instead of being lowered and raised again.
   task automatic send_elem(input logic first, input int er, input int ei,
                            input int rr, input int ri);
      req_chan.valid           <= 1'b1;
      req_chan.first_of_system <= first;
      req_chan.elem_re         <= er;
      req_chan.elem_im         <= ei;
      req_chan.rhs_re          <= rr;
      req_chan.rhs_im          <= ri;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
      if ($urandom_range(99) < tx_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_pct);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      req_chan.valid <= 1'b0;
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      if (idx == CSR_LAMBDA) lambda_now = value;
      else order_now = value;
   endtask

   // Registers may only change once every solved word is out and the block has
   // had time to finish an element that produces no word. The task first waits for an edge
   // so that the checker has counted the word accepted at the last edge.
   task automatic wait_quiet();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Rows first_row..last_row of a system in row-major order, columns 0 to the
   // diagonal. The first word of row 0 carries the first mark when asked for.
   task automatic send_rows(input int first_row, input int last_row, input logic mark);
      int rr, ri;
      for (int r = first_row; r <= last_row; r++) begin
         rr = rand_q();
         ri = rand_q();
         for (int c = 0; c <= r; c++) begin
            if (c == r) send_elem(mark && r == 0, rand_diag_re(), rand_q() / 4, rr, ri);
            else send_elem(mark && r == 0 && c == 0, rand_q(), rand_q(), rr, ri);
         end
      end
   endtask

   initial begin
      int n, target;
      reset = 1'b1;
      cycles = 0;
      words_sent = 0;
      tx_pct = 0;
      rx_pct = 0;
      lambda_now = 0;
      order_now = 64;
      req_chan.valid = 1'b0;
      req_chan.first_of_system = 1'b0;
      req_chan.elem_re = '0;
      req_chan.elem_im = '0;
      req_chan.rhs_re = '0;
      req_chan.rhs_im = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_LAMBDA;
      csr_chan.data = '0;
      rsp_chan.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a third-order system whose first two rows hold fixed values, the last row random.
      write_reg(CSR_ORDER, 3);
      send_elem(1'b1, Q_ONE, 0, 2 * Q_ONE, Q_ONE);
      send_elem(1'b0, Q_ONE / 2, Q_ONE, 3 * Q_ONE, 0);
      send_elem(1'b0, 2 * Q_ONE, 0, 3 * Q_ONE, 0);
      send_rows(2, 2, 1'b0);

      // Extremes of the fields on first-order systems, including a zero divisor
      // and a largest lambda that saturates the diagonal.
      wait_quiet();
      write_reg(CSR_ORDER, 1);
      send_elem(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_elem(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_elem(1'b1, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_elem(1'b1, 0, 0, Q_ONE, Q_ONE);
      wait_quiet();
      write_reg(CSR_LAMBDA, 32'h7FFF_FFFF);
      send_elem(1'b1, 32'h7FFF_FFFF, 0, Q_ONE, -Q_ONE);
      wait_quiet();
      write_reg(CSR_LAMBDA, 32'h8000_0000);
      send_elem(1'b1, 32'h8000_0000, 3, -Q_ONE, Q_ONE);
      wait_quiet();
      write_reg(CSR_LAMBDA, 5 * Q_ONE);
      send_elem(1'b1, -5 * Q_ONE, 0, Q_ONE, Q_ONE);

      // Order zero acts as one and an order above the maximum acts as the maximum.
      wait_quiet();
      write_reg(CSR_ORDER, 0);
      send_rows(0, 0, 1'b1);
      wait_quiet();
      write_reg(CSR_ORDER, 127);
      send_rows(0, 1, 1'b1);

      // Without first marks the block must wrap to row 0 after the last unknown.
      wait_quiet();
      write_reg(CSR_ORDER, 2);
      send_rows(0, 1, 1'b0);
      send_rows(0, 0, 1'b0);

      // Order lowered mid-system: the next diagonal is past the order, so it is
      // flagged last and the block starts again at row 0.
      wait_quiet();
      write_reg(CSR_ORDER, 64);
      send_rows(0, 1, 1'b1);
      wait_quiet();
      write_reg(CSR_ORDER, 2);
      send_rows(2, 2, 1'b0);
      send_rows(0, 0, 1'b0);

      // Random part in three idling phases: receiver-heavy, sender-heavy, none.
      for (int ph = 0; ph < 3; ph++) begin
         tx_pct = (ph == 0) ? 34 : ((ph == 1) ? 48 : 0);
         rx_pct = (ph == 0) ? 48 : ((ph == 1) ? 34 : 0);
         target = words_sent + 233;
         while (words_sent < target) begin
            n = ($urandom_range(15) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
            if ($urandom_range(4) != 0) begin
               // Well-formed system, with fresh registers now and then.
               if (n != order_now || $urandom_range(3) == 0) begin
                  wait_quiet();
                  if ($urandom_range(1) == 1) begin
                     case ($urandom_range(5))
                        0: write_reg(CSR_LAMBDA, rand_q());
                        1: write_reg(CSR_LAMBDA, 0);
                        default: write_reg(CSR_LAMBDA,
                                           int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
                     endcase
                  end
                  write_reg(CSR_ORDER, n);
               end
               send_rows(0, n - 1, 1'b1);
            end else begin
               // Broken sequences: wrong length for the order, missing marks, or
               // a system cut short by a new first mark.
               case ($urandom_range(2))
                  0: send_rows(0, n - 1, 1'b1);
                  1: send_rows(0, n - 1, 1'b0);
                  default: begin
                     for (int k = 0; k < n; k++) begin
                        send_elem($urandom_range(3) == 0, rand_q(), rand_q(),
                                  rand_q(), rand_q());
                     end
                  end
               endcase
            end
         end
      end

      // Drain: every expected word must come out, then let the block settle.
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire
